@@ sv/pmd_pkg.sv @@
`default_nettype none

package pmd_pkg;

    localparam int MAX_CITIES = 32;
    localparam int DIST_WIDTH = 24;
    localparam int VTX_W      = 6;
    localparam int IDX_W      = $clog2(MAX_CITIES);
    localparam int MEM_AW     = 2 * IDX_W;
    localparam int MEM_DEPTH  = MAX_CITIES * MAX_CITIES;

    typedef logic [VTX_W-1:0]      t_vtx;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [DIST_WIDTH-1:0] t_dist;

    localparam t_dist DIST_INF = '1;
    localparam t_vtx  VTX_NONE = '0;
    localparam t_vtx  VTX_MAX  = VTX_W'(MAX_CITIES);
    localparam t_vtx  VTX_MIN  = VTX_W'(2);

    // controller to datapath
    typedef struct packed {
        logic init;
        logic issue;
        logic take_pick;
        logic emit;
        logic last;
        t_vtx v;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pipe_vld;
    } t_sts;

    function automatic t_idx vtx_to_idx(input t_vtx v);
        t_vtx d;
        d = v - VTX_W'(1);
        return d[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/pmd_ctrl.sv @@
`default_nettype none

module pmd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_run,
    input  wire pmd_pkg::t_vtx i_city_count,
    input  wire pmd_pkg::t_sts i_sts,
    output pmd_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import pmd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_RELAX = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state, n_state;
    t_vtx       r_n, n_n;
    t_vtx       r_v, n_v;
    t_vtx       r_round, n_round;
    t_vtx       clamped;

    always_comb begin
        if (i_city_count < VTX_MIN) begin
            clamped = VTX_MIN;
        end else if (i_city_count > VTX_MAX) begin
            clamped = VTX_MAX;
        end else begin
            clamped = i_city_count;
        end
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_v     = r_v;
        n_round = r_round;
        o_cmd   = '0;
        o_cmd.v = r_v;
        unique case (r_state)
            S_IDLE: begin
                if (i_run) begin
                    n_n     = clamped;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_v        = VTX_W'(1);
                n_round    = VTX_W'(1);
                n_state    = S_RELAX;
            end
            S_RELAX: begin
                o_cmd.issue = 1'b1;
                if (r_v == r_n) begin
                    n_state = S_DRAIN;
                end else begin
                    n_v = r_v + VTX_W'(1);
                end
            end
            S_DRAIN: begin
                // wait for the last compare, then the running minimum is final
                if (!i_sts.pipe_vld) begin
                    if (r_round == r_n - VTX_W'(1)) begin
                        n_v     = VTX_MIN;
                        n_state = S_OUT;
                    end else begin
                        o_cmd.take_pick = 1'b1;
                        n_round         = r_round + VTX_W'(1);
                        n_v             = VTX_W'(1);
                        n_state         = S_RELAX;
                    end
                end
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                o_cmd.last = (r_v == r_n);
                if (r_v == r_n) begin
                    n_state = S_IDLE;
                end else begin
                    n_v = r_v + VTX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= VTX_MAX;
            r_v     <= '0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_v     <= n_v;
            r_round <= n_round;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ sv/pmd_dp.sv @@
`default_nettype none

module pmd_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr_en,
    input  wire pmd_pkg::t_vtx  i_row,
    input  wire pmd_pkg::t_vtx  i_col,
    input  wire pmd_pkg::t_dist i_distance,
    input  wire pmd_pkg::t_cmd  i_cmd,
    output pmd_pkg::t_sts       o_sts,
    output logic                o_result_valid,
    output pmd_pkg::t_vtx       o_vertex,
    output pmd_pkg::t_vtx       o_parent,
    output pmd_pkg::t_dist      o_edge_weight,
    output logic                o_last_edge
);
    import pmd_pkg::*;

    // distance matrix, row major, undefined until written
    t_dist mem [0:MEM_DEPTH-1];
    t_dist r_rd;

    t_dist r_key [0:MAX_CITIES-1];
    t_vtx  r_par [0:MAX_CITIES-1];
    logic [MAX_CITIES-1:0] r_kvld;
    logic [MAX_CITIES-1:0] r_in_tree;

    t_idx  r_pick;
    t_dist r_min_key;
    t_vtx  r_min_v;
    logic  r_pvld;
    t_vtx  r_pv;

    logic              wr_ok;
    logic [MEM_AW-1:0] wr_addr;
    logic [MEM_AW-1:0] rd_addr;
    t_idx              s_idx;
    t_dist             s_cur;
    logic              s_lower;
    t_dist             s_new;
    logic              s_cand;
    logic              s_better;
    t_idx              o_idx;

    assign wr_ok   = i_wr_en && (i_row != VTX_NONE) && (i_row <= VTX_MAX)
                     && (i_col != VTX_NONE) && (i_col <= VTX_MAX);
    assign wr_addr = {vtx_to_idx(i_row), vtx_to_idx(i_col)};
    assign rd_addr = {r_pick, vtx_to_idx(i_cmd.v)};

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[wr_addr] <= i_distance;
        end
        if (i_cmd.issue) begin
            r_rd <= mem[rd_addr];
        end
    end

    // compare stage: one vertex per cycle against the picked vertex's row
    assign s_idx    = vtx_to_idx(r_pv);
    assign s_cur    = r_kvld[s_idx] ? r_key[s_idx] : DIST_INF;
    assign s_lower  = (r_rd < s_cur);
    assign s_new    = s_lower ? r_rd : s_cur;
    assign s_cand   = r_pvld && !r_in_tree[s_idx];
    assign s_better = s_cand && ((r_min_v == VTX_NONE) || (s_new < r_min_key));

    always_ff @(posedge i_clk) begin
        r_pv <= i_cmd.v;
        if (s_cand && s_lower) begin
            r_key[s_idx] <= r_rd;
            r_par[s_idx] <= VTX_W'({1'b0, r_pick}) + VTX_W'(1);
        end
        if (s_better) begin
            r_min_key <= s_new;
        end
        if (i_cmd.init) begin
            r_pick <= '0;
        end else if (i_cmd.take_pick) begin
            r_pick <= vtx_to_idx(r_min_v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kvld    <= '0;
            r_in_tree <= '0;
            r_min_v   <= VTX_NONE;
            r_pvld    <= 1'b0;
        end else begin
            r_pvld <= i_cmd.issue;
            if (i_cmd.init) begin
                r_kvld    <= '0;
                r_in_tree <= MAX_CITIES'(1);
                r_min_v   <= VTX_NONE;
            end else if (i_cmd.take_pick) begin
                r_in_tree[vtx_to_idx(r_min_v)] <= 1'b1;
                r_min_v                        <= VTX_NONE;
            end else begin
                if (s_cand && s_lower) begin
                    r_kvld[s_idx] <= 1'b1;
                end
                if (s_better) begin
                    r_min_v <= r_pv;
                end
            end
        end
    end

    assign o_sts.pipe_vld = r_pvld;

    // result registers
    assign o_idx = vtx_to_idx(i_cmd.v);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_vertex      <= i_cmd.v;
            o_parent      <= r_kvld[o_idx] ? r_par[o_idx] : VTX_NONE;
            o_edge_weight <= r_kvld[o_idx] ? r_key[o_idx] : DIST_INF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
            o_last_edge    <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.emit;
            o_last_edge    <= i_cmd.emit && i_cmd.last;
        end
    end

endmodule

`default_nettype wire

@@ sv/prim_mst_dense.sv @@
// dense minimum spanning tree engine (prim, grown from vertex 1)
// input channel: a word is taken on a rising edge with start high and busy low;
//   it writes distance[row][col] into the 32x32 matrix memory (rows and cols
//   outside 1..32 are dropped). with i_start_req set the engine then runs.
// result channel: one word per vertex 2..n in ascending order, each shown for
//   exactly one cycle under o_result_valid; o_last_edge marks vertex n.
//   the receiver cannot stall, results are never held back.
// config: apb register 0 holds city_count; n is city_count clamped to 2..32.
// input: plain writes are taken back to back while busy is low.
// a run grows the tree in n-1 rounds, then issues the n-1 results.
//   each round streams one matrix row through a single memory read port,
//   one entry a cycle, then waits in the drain state for the running minimum to settle.
//   busy stays high from the start word until the last result is issued.
// reset: clears the controller, tree flags and result strobe; city_count
//   returns to 32. the matrix keeps no reset and must be written before use.
`default_nettype none

module prim_mst_dense (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // command channel
    input  wire logic           start,
    output logic                busy,
    input  wire pmd_pkg::t_vtx  i_row,
    input  wire pmd_pkg::t_vtx  i_col,
    input  wire pmd_pkg::t_dist i_distance,
    input  wire logic           i_start_req,
    // result channel
    output logic                o_result_valid,
    output pmd_pkg::t_vtx       o_vertex,
    output pmd_pkg::t_vtx       o_parent,
    output pmd_pkg::t_dist      o_edge_weight,
    output logic                o_last_edge,
    // apb config port
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [1:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import pmd_pkg::*;

    logic accept;
    logic run;
    t_vtx r_city_count;
    t_cmd cmd;
    t_sts sts;

    // word accepted when start is high and the engine is not running
    assign accept = start && !busy;
    assign run    = accept && i_start_req;

    // single register: writes at every address reach it, reads return it only at address 0
    assign pready = 1'b1;
    assign prdata = {{(32 - VTX_W){1'b0}}, r_city_count} & {32{paddr == 2'd0}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_city_count <= VTX_MAX;
        end else if (psel && penable && pwrite && pready) begin
            r_city_count <= pwdata[VTX_W-1:0];
        end
    end

    pmd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_run        (run),
        .i_city_count (r_city_count),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_busy       (busy)
    );

    pmd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en        (accept),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_distance     (i_distance),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result_valid (o_result_valid),
        .o_vertex       (o_vertex),
        .o_parent       (o_parent),
        .o_edge_weight  (o_edge_weight),
        .o_last_edge    (o_last_edge)
    );

endmodule

`default_nettype wire

@@ sv/pmd_chk.sv @@
`default_nettype none

module pmd_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_start_req,
    input wire logic o_result_valid,
    input wire logic o_last_edge
);

    // results only come out of a run
    a_res_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result word outside a run");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_edge |-> o_result_valid)
        else $error("last flag without a result word");

    // results of one run are contiguous and end at the last flag
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last_edge) |=> o_result_valid)
        else $error("gap inside result burst");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_edge) |=> !o_result_valid)
        else $error("result after last word");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_start_req) |=> busy)
        else $error("run did not raise busy");

endmodule

bind prim_mst_dense pmd_chk u_pmd_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_start_req    (i_start_req),
    .o_result_valid (o_result_valid),
    .o_last_edge    (o_last_edge)
);

`default_nettype wire
